// ----- rtl/bwlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_pkg
// Shared types and register indexes of the fourth-order low-pass filter.
// ----------------------------------------------------------------------------
package bwlp_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int GUARD_BITS = 8;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_INPUT_GAIN = 3'd0;
  localparam cfg_index_t REG_S1_A1 = 3'd1;
  localparam cfg_index_t REG_S1_A2 = 3'd2;
  localparam cfg_index_t REG_S2_A1 = 3'd3;
  localparam cfg_index_t REG_S2_A2 = 3'd4;

  typedef struct packed {
    logic ld;
    logic clear;
  } sect_ctrl_t;

endpackage

// ----- rtl/bwlp_gain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_gain
// Input gain stage: sample times unsigned Q0.32 gain, rounded into node format.
// ----------------------------------------------------------------------------
module bwlp_gain #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32
) (
  input  logic                                                clk,
  input  logic                                                ld,
  input  logic signed [SAMPLE_WIDTH-1:0]                      sample,
  input  logic        [COEF_WIDTH-1:0]                        gain,
  output logic signed [SAMPLE_WIDTH+bwlp_pkg::GUARD_BITS-1:0] x
);

  localparam int NW = SAMPLE_WIDTH + bwlp_pkg::GUARD_BITS;
  localparam int GPW = SAMPLE_WIDTH + COEF_WIDTH + 1;
  localparam logic signed [GPW-1:0] HALF = GPW'(1) << (COEF_WIDTH - 1);

  logic signed [GPW-1:0] prod;
  logic signed [GPW-1:0] prod_rnd;
  logic signed [NW-1:0]  x_next;

  assign prod = GPW'(sample) * GPW'($signed({1'b0, gain}));
  assign prod_rnd = prod + HALF;
  // rounded value fits in SAMPLE_WIDTH+1 bits, so the node never saturates here
  assign x_next = NW'($signed(prod_rnd[GPW-1:COEF_WIDTH]));

  always_ff @(posedge clk) begin
    if (ld) begin
      x <= x_next;
    end
  end

endmodule

// ----- rtl/bwlp_section.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlp_section
// Direct-form-II biquad section with numerator 1, 2, 1 and saturating nodes.
// ----------------------------------------------------------------------------
module bwlp_section #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  bwlp_pkg::sect_ctrl_t                                ctrl,
  input  logic signed [COEF_WIDTH-1:0]                        a1,
  input  logic signed [COEF_WIDTH-1:0]                        a2,
  input  logic signed [SAMPLE_WIDTH+bwlp_pkg::GUARD_BITS-1:0] x_in,
  input  logic                                                clip_in,
  output logic signed [SAMPLE_WIDTH+bwlp_pkg::GUARD_BITS-1:0] y,
  output logic                                                clip
);

  localparam int NW = SAMPLE_WIDTH + bwlp_pkg::GUARD_BITS;
  localparam int PW = NW + COEF_WIDTH;
  localparam int SUMW = NW + 4;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (COEF_WIDTH - 3);
  localparam logic signed [SUMW-1:0] NODE_MAX = {{(SUMW-NW+1){1'b0}}, {(NW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] NODE_MIN = ~NODE_MAX;

  logic signed [NW-1:0]   h1;
  logic signed [NW-1:0]   h2;
  logic signed [PW-1:0]   p1;
  logic signed [PW-1:0]   p2;
  logic signed [PW-1:0]   p1_rnd;
  logic signed [PW-1:0]   p2_rnd;
  logic signed [SUMW-1:0] w_full;
  logic signed [SUMW-1:0] y_full;
  logic signed [NW-1:0]   w_sat;
  logic signed [NW-1:0]   y_sat;
  logic                   w_clip;
  logic                   y_clip;

  assign p1 = PW'(h1) * PW'(a1);
  assign p2 = PW'(h2) * PW'(a2);
  assign p1_rnd = p1 + HALF;
  assign p2_rnd = p2 + HALF;

  assign w_full = SUMW'(x_in)
                - SUMW'($signed(p1_rnd[PW-1:COEF_WIDTH-2]))
                - SUMW'($signed(p2_rnd[PW-1:COEF_WIDTH-2]));

  always_comb begin
    w_clip = 1'b0;
    if (w_full > NODE_MAX) begin
      w_sat = NODE_MAX[NW-1:0];
      w_clip = 1'b1;
    end else if (w_full < NODE_MIN) begin
      w_sat = NODE_MIN[NW-1:0];
      w_clip = 1'b1;
    end else begin
      w_sat = w_full[NW-1:0];
    end
  end

  assign y_full = SUMW'(w_sat) + (SUMW'(h1) <<< 1) + SUMW'(h2);

  always_comb begin
    y_clip = 1'b0;
    if (y_full > NODE_MAX) begin
      y_sat = NODE_MAX[NW-1:0];
      y_clip = 1'b1;
    end else if (y_full < NODE_MIN) begin
      y_sat = NODE_MIN[NW-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat = y_full[NW-1:0];
    end
  end

  // history
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      h1 <= '0;
      h2 <= '0;
    end else if (ctrl.ld) begin
      h1 <= w_sat;
      h2 <= h1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld) begin
      y <= y_sat;
      clip <= clip_in | w_clip | y_clip;
    end
  end

endmodule

// ----- rtl/butterworth_lowpass_4th_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterworth_lowpass_4th_order
// Fourth-order low-pass filter, two cascaded biquad sections.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall carrying sample_in (signed Q1.23).
// Each accepted word yields one output word on out_valid/out_stall carrying
// sample_out (saturated Q1.23) and clipped, set when any node or the output
// saturated for that sample.
// Five-stage pipeline: input register, gain multiply, section 1, section 2,
// output saturation register. out_valid rises once the word is loaded into
// the output register; throughput is one word per cycle while out_stall is
// low, as each section's recursive multiply-add is combinational.
// Stages collapse bubbles: when out_stall holds a word, upstream stages keep
// filling and in_stall rises only when all five stages are occupied.
// Coefficients are written on the cfg port (always ready) by the user only
// while the filter is idle; the block does not enforce this. A write to any
// defined register clears both sections' history. Reset clears the
// coefficient registers, the history and the pipeline valid flags.
// ----------------------------------------------------------------------------
module butterworth_lowpass_4th_order #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic                                 clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  bwlp_pkg::cfg_index_t                 cfg_index,
  input  logic        [COEF_WIDTH-1:0]         cfg_data
);

  localparam int NW = SAMPLE_WIDTH + bwlp_pkg::GUARD_BITS;
  localparam int STAGES = 5;
  localparam logic signed [NW-1:0] OUT_MAX = {{(NW-SAMPLE_WIDTH+1){1'b0}},
                                              {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [NW-1:0] OUT_MIN = ~OUT_MAX;

  logic        [COEF_WIDTH-1:0]   input_gain;
  logic signed [COEF_WIDTH-1:0]   s1_a1;
  logic signed [COEF_WIDTH-1:0]   s1_a2;
  logic signed [COEF_WIDTH-1:0]   s2_a1;
  logic signed [COEF_WIDTH-1:0]   s2_a2;

  logic [STAGES-1:0]              v;
  logic [STAGES-1:0]              rdy;
  logic [STAGES-1:0]              ld;
  logic                           cfg_wr;
  logic                           hist_clear;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [NW-1:0]           x;
  logic signed [NW-1:0]           y1;
  logic signed [NW-1:0]           y2;
  logic                           clip1;
  logic                           clip2;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_next;
  logic                           clipped_next;

  bwlp_pkg::sect_ctrl_t           ctrl1;
  bwlp_pkg::sect_ctrl_t           ctrl2;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    hist_clear = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        bwlp_pkg::REG_INPUT_GAIN,
        bwlp_pkg::REG_S1_A1,
        bwlp_pkg::REG_S1_A2,
        bwlp_pkg::REG_S2_A1,
        bwlp_pkg::REG_S2_A2: hist_clear = 1'b1;
        default: hist_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain <= '0;
      s1_a1 <= '0;
      s1_a2 <= '0;
      s2_a1 <= '0;
      s2_a2 <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        bwlp_pkg::REG_INPUT_GAIN: input_gain <= cfg_data;
        bwlp_pkg::REG_S1_A1: s1_a1 <= $signed(cfg_data);
        bwlp_pkg::REG_S1_A2: s1_a2 <= $signed(cfg_data);
        bwlp_pkg::REG_S2_A1: s2_a1 <= $signed(cfg_data);
        bwlp_pkg::REG_S2_A2: s2_a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    ld[0] = in_valid && rdy[0];
    for (int i = 1; i < STAGES; i++) begin
      ld[i] = v[i-1] && rdy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v[0] <= ld[0] || (v[0] && !rdy[0]);
      for (int i = 1; i < STAGES; i++) begin
        v[i] <= ld[i] || (v[i] && !rdy[i]);
      end
    end
  end

  assign in_stall = !rdy[0];
  assign out_valid = v[STAGES-1];

  // datapath
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sample <= sample_in;
    end
  end

  bwlp_gain #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_gain (
    .clk   (clk),
    .ld    (ld[1]),
    .sample(sample),
    .gain  (input_gain),
    .x     (x)
  );

  assign ctrl1 = '{ld: ld[2], clear: hist_clear};
  assign ctrl2 = '{ld: ld[3], clear: hist_clear};

  bwlp_section #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_sect1 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl1),
    .a1     (s1_a1),
    .a2     (s1_a2),
    .x_in   (x),
    .clip_in(1'b0),
    .y      (y1),
    .clip   (clip1)
  );

  bwlp_section #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_sect2 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl2),
    .a1     (s2_a1),
    .a2     (s2_a2),
    .x_in   (y1),
    .clip_in(clip1),
    .y      (y2),
    .clip   (clip2)
  );

  // output saturation
  always_comb begin
    clipped_next = clip2;
    if (y2 > OUT_MAX) begin
      sample_out_next = OUT_MAX[SAMPLE_WIDTH-1:0];
      clipped_next = 1'b1;
    end else if (y2 < OUT_MIN) begin
      sample_out_next = OUT_MIN[SAMPLE_WIDTH-1:0];
      clipped_next = 1'b1;
    end else begin
      sample_out_next = y2[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[STAGES-1]) begin
      sample_out <= sample_out_next;
      clipped <= clipped_next;
    end
  end

  // stall only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v == {STAGES{1'b1}}))
    else $error("input stalled with a free pipeline stage");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ld[STAGES-1] |=> out_valid)
    else $error("output load not followed by valid word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v[STAGES-2]) |=> !out_valid)
    else $error("output word repeated");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v[STAGES-2] && out_valid && out_stall) |=> v[STAGES-2])
    else $error("word lost behind stalled output");

endmodule
